// ----- hdl/stok_pkg.sv -----
// Package for the source tokenizer: scan modes, token kinds, character
// codes, the queued token record and the character classification functions.
// No dependencies.
`default_nettype none

package stok_pkg;

  // Offset, length, token kind and character widths
  localparam int unsigned OffsetWidth = 16;
  localparam int unsigned LenWidth    = 16;
  localparam int unsigned KindWidth   = 5;
  localparam int unsigned CharWidth   = 8;

  // Result queue depth and pointer width
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrWidth   = $clog2(QueueDepth);
  localparam int unsigned CntWidth   = $clog2(QueueDepth + 1);

  typedef logic [OffsetWidth-1:0] offset_t;
  typedef logic [LenWidth-1:0]    len_t;
  typedef logic [KindWidth-1:0]   kind_t;
  typedef logic [CharWidth-1:0]   char_t;

  // Scanner mode
  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeIdent   = 3'd1,
    ModeNumber  = 3'd2,
    ModePendEq  = 3'd3,
    ModePendNot = 3'd4
  } scan_mode_e;

  // Token kinds
  localparam kind_t KindIllegal = 5'd0;
  localparam kind_t KindEnd     = 5'd1;
  localparam kind_t KindIdent   = 5'd2;
  localparam kind_t KindInt     = 5'd3;
  localparam kind_t KindString  = 5'd4;
  localparam kind_t KindAssign  = 5'd5;
  localparam kind_t KindEq      = 5'd6;
  localparam kind_t KindNe      = 5'd7;
  localparam kind_t KindNot     = 5'd8;
  localparam kind_t KindComma   = 5'd9;
  localparam kind_t KindSemi    = 5'd10;
  localparam kind_t KindPlus    = 5'd11;
  localparam kind_t KindMinus   = 5'd12;
  localparam kind_t KindDiv     = 5'd13;
  localparam kind_t KindMult    = 5'd14;
  localparam kind_t KindLess    = 5'd15;
  localparam kind_t KindGreater = 5'd16;
  localparam kind_t KindColon   = 5'd17;
  localparam kind_t KindLParen  = 5'd18;
  localparam kind_t KindRParen  = 5'd19;
  localparam kind_t KindLCurl   = 5'd20;
  localparam kind_t KindRCurl   = 5'd21;
  localparam kind_t KindLBrac   = 5'd22;
  localparam kind_t KindRBrac   = 5'd23;

  // Character codes
  localparam char_t ChEnd     = 8'h00;
  localparam char_t ChTab     = 8'h09;
  localparam char_t ChCr      = 8'h0D;
  localparam char_t ChSpace   = 8'h20;
  localparam char_t ChBang    = 8'h21;
  localparam char_t ChQuote   = 8'h22;
  localparam char_t ChLParen  = 8'h28;
  localparam char_t ChRParen  = 8'h29;
  localparam char_t ChStar    = 8'h2A;
  localparam char_t ChPlus    = 8'h2B;
  localparam char_t ChComma   = 8'h2C;
  localparam char_t ChMinus   = 8'h2D;
  localparam char_t ChSlash   = 8'h2F;
  localparam char_t ChZero    = 8'h30;
  localparam char_t ChNine    = 8'h39;
  localparam char_t ChColon   = 8'h3A;
  localparam char_t ChSemi    = 8'h3B;
  localparam char_t ChLess    = 8'h3C;
  localparam char_t ChEquals  = 8'h3D;
  localparam char_t ChGreater = 8'h3E;
  localparam char_t ChUpperA  = 8'h41;
  localparam char_t ChUpperZ  = 8'h5A;
  localparam char_t ChLBrac   = 8'h5B;
  localparam char_t ChRBrac   = 8'h5D;
  localparam char_t ChUnder   = 8'h5F;
  localparam char_t ChLowerA  = 8'h61;
  localparam char_t ChLowerZ  = 8'h7A;
  localparam char_t ChLCurl   = 8'h7B;
  localparam char_t ChRCurl   = 8'h7D;

  // One queued token
  typedef struct packed {
    kind_t   kind;
    offset_t start;
    len_t    len;
    logic    last;
  } token_t;

  function automatic logic is_letter(char_t c);
    return ((c >= ChLowerA) && (c <= ChLowerZ)) ||
           ((c >= ChUpperA) && (c <= ChUpperZ)) || (c == ChUnder);
  endfunction

  function automatic logic is_digit(char_t c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_space(char_t c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  // Single-character punctuation; anything unknown is illegal.
  function automatic kind_t punct_kind(char_t c);
    kind_t k;
    k = KindIllegal;
    case (c)
      ChComma:   k = KindComma;
      ChSemi:    k = KindSemi;
      ChPlus:    k = KindPlus;
      ChMinus:   k = KindMinus;
      ChSlash:   k = KindDiv;
      ChStar:    k = KindMult;
      ChLess:    k = KindLess;
      ChGreater: k = KindGreater;
      ChColon:   k = KindColon;
      ChLParen:  k = KindLParen;
      ChRParen:  k = KindRParen;
      ChLCurl:   k = KindLCurl;
      ChRCurl:   k = KindRCurl;
      ChLBrac:   k = KindLBrac;
      ChRBrac:   k = KindRBrac;
      default:   k = KindIllegal;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/source_tokenizer.sv -----
// Source tokenizer top level: scanner state, token classification and the
// result queue. Depends on stok_pkg.
`default_nettype none

// The tokenizer takes one character byte per cycle on the slave stream while
// ready and emits tokens (kind, start offset, length) on the master stream, one
// token per cycle while the sink takes them. A character causes zero, one or
// two tokens; a byte of zero ends the input, emits END and rewinds the offset
// to zero. The scanner updates in the cycle a character is accepted and writes
// its tokens into a four-entry result queue; the slave side is ready while at
// most two tokens are queued, so input runs at one character per cycle as long
// as the token rate does not exceed one per cycle on average and the sink keeps
// taking results. The last token caused by one character carries tlast.
module source_tokenizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Character input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  // Token output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [4:0] token_kind, [20:5] start_offset,
                                           // [36:21] token_length, [39:37] zero
  output logic             m_axis_tlast    // last_of_run
);

  stok_pkg::scan_mode_e mode_q, mode_d;
  stok_pkg::offset_t    start_q, start_d;
  stok_pkg::offset_t    pos_q, pos_d;
  stok_pkg::len_t       len_q, len_d;

  stok_pkg::token_t     queue_q [stok_pkg::QueueDepth];
  logic [stok_pkg::PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [stok_pkg::PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [stok_pkg::PtrWidth-1:0] wr_ptr_next;
  logic [stok_pkg::CntWidth-1:0] cnt_q, cnt_d;

  logic                 accept;
  logic                 pop;
  stok_pkg::char_t      c;
  stok_pkg::offset_t    pos_adv;
  logic                 pre_v, post_v, done;
  stok_pkg::token_t     pre_tok, post_tok;
  stok_pkg::token_t     tok0, tok1;
  logic [1:0]           n_tok;

  assign c       = s_axis_tdata;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign pop     = m_axis_tvalid && m_axis_tready;
  assign pos_adv = (pos_q == '1) ? pos_q : pos_q + stok_pkg::OffsetWidth'(1);

  // Scanner: token closed by this character, then token it starts.
  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    pos_d    = pos_q;
    len_d    = len_q;
    pre_v    = 1'b0;
    post_v   = 1'b0;
    done     = 1'b0;
    pre_tok  = '0;
    post_tok = '0;

    unique case (mode_q)
      stok_pkg::ModeIdent, stok_pkg::ModeNumber: begin
        if ((mode_q == stok_pkg::ModeIdent && stok_pkg::is_letter(c)) ||
            (mode_q == stok_pkg::ModeNumber && stok_pkg::is_digit(c))) begin
          done  = 1'b1;
          len_d = (len_q == '1) ? len_q : len_q + stok_pkg::LenWidth'(1);
          pos_d = pos_adv;
        end else begin
          pre_v         = 1'b1;
          pre_tok.kind  = (mode_q == stok_pkg::ModeIdent) ? stok_pkg::KindIdent
                                                          : stok_pkg::KindInt;
          pre_tok.start = start_q;
          pre_tok.len   = len_q;
        end
      end
      stok_pkg::ModePendEq, stok_pkg::ModePendNot: begin
        pre_v         = 1'b1;
        pre_tok.start = start_q;
        if (c == stok_pkg::ChEquals) begin
          done         = 1'b1;
          pre_tok.kind = (mode_q == stok_pkg::ModePendEq) ? stok_pkg::KindEq
                                                          : stok_pkg::KindNe;
          pre_tok.len  = stok_pkg::LenWidth'(2);
          mode_d       = stok_pkg::ModeIdle;
          pos_d        = pos_adv;
        end else begin
          pre_tok.kind = (mode_q == stok_pkg::ModePendEq) ? stok_pkg::KindAssign
                                                          : stok_pkg::KindNot;
          pre_tok.len  = stok_pkg::LenWidth'(1);
        end
      end
      default: begin
      end
    endcase

    // Fresh character handled as from idle
    if (!done) begin
      mode_d         = stok_pkg::ModeIdle;
      post_tok.start = pos_q;
      post_tok.len   = stok_pkg::LenWidth'(1);
      if (c == stok_pkg::ChEnd) begin
        post_v        = 1'b1;
        post_tok.kind = stok_pkg::KindEnd;
        post_tok.len  = '0;
        pos_d         = '0;
        start_d       = '0;
        len_d         = '0;
      end else begin
        pos_d = pos_adv;
        if (stok_pkg::is_space(c)) begin
          // Whitespace is skipped.
        end else if (stok_pkg::is_letter(c) || stok_pkg::is_digit(c)) begin
          mode_d  = stok_pkg::is_letter(c) ? stok_pkg::ModeIdent : stok_pkg::ModeNumber;
          start_d = pos_q;
          len_d   = stok_pkg::LenWidth'(1);
        end else if (c == stok_pkg::ChEquals || c == stok_pkg::ChBang) begin
          mode_d  = (c == stok_pkg::ChEquals) ? stok_pkg::ModePendEq
                                              : stok_pkg::ModePendNot;
          start_d = pos_q;
          len_d   = stok_pkg::LenWidth'(1);
        end else if (c == stok_pkg::ChQuote) begin
          post_v        = 1'b1;
          post_tok.kind = stok_pkg::KindString;
        end else begin
          post_v        = 1'b1;
          post_tok.kind = stok_pkg::punct_kind(c);
        end
      end
    end
  end

  // Order the tokens and mark the final one.
  always_comb begin
    tok0      = pre_v ? pre_tok : post_tok;
    tok1      = post_tok;
    tok0.last = !(pre_v && post_v);
    tok1.last = 1'b1;
    n_tok     = {1'b0, pre_v} + {1'b0, post_v};
  end

  // Queue pointers and fill level
  assign s_axis_tready = (cnt_q <= stok_pkg::CntWidth'(2));
  assign m_axis_tvalid = (cnt_q != '0);
  assign wr_ptr_next   = wr_ptr_q + stok_pkg::PtrWidth'(1);

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    if (pop) begin
      rd_ptr_d = rd_ptr_q + stok_pkg::PtrWidth'(1);
    end
    if (accept) begin
      wr_ptr_d = wr_ptr_q + stok_pkg::PtrWidth'(n_tok);
    end
    cnt_d = cnt_q + (accept ? stok_pkg::CntWidth'(n_tok) : '0)
                  - (pop ? stok_pkg::CntWidth'(1) : '0);
  end

  // Scanner and queue control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= stok_pkg::ModeIdle;
      start_q  <= '0;
      pos_q    <= '0;
      len_q    <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        mode_q  <= mode_d;
        start_q <= start_d;
        pos_q   <= pos_d;
        len_q   <= len_d;
      end
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue payload; the second token of a character goes one slot further.
  always_ff @(posedge clk_i) begin
    if (accept && n_tok != 2'd0) begin
      queue_q[wr_ptr_q] <= tok0;
    end
    if (accept && n_tok == 2'd2) begin
      queue_q[wr_ptr_next] <= tok1;
    end
  end

  // Output packing
  always_comb begin
    m_axis_tdata = {3'b000, queue_q[rd_ptr_q].len, queue_q[rd_ptr_q].start,
                    queue_q[rd_ptr_q].kind};
    m_axis_tlast = queue_q[rd_ptr_q].last;
  end

endmodule

`default_nettype wire
